/* hdl/tml_pkg.sv */
// Shared types, constants and arithmetic helpers for the triplet margin loss unit.
`timescale 1ns / 1ps
package tml_pkg;

  localparam int ElemBits  = 16;
  localparam int AccBits   = 48;
  localparam int DiffBits  = ElemBits + 2;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int RadBits   = 56;
  localparam int RootBits  = RadBits / 2;
  localparam int OutBits   = 32;
  localparam int MarginBits = 31;
  localparam int DistBits  = 18;
  localparam int QuotBits  = 17;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 32;

  localparam logic [CfgIdxBits-1:0] CFG_DISTANCE_MODE     = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_MARGIN            = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_DIFFERENCE_OFFSET = 2'd2;
  localparam logic [CfgIdxBits-1:0] CFG_NORM_OFFSET       = 2'd3;

  localparam logic MODE_EUCLID = 1'b0;
  localparam logic MODE_COSINE = 1'b1;

  typedef logic signed [AccBits-1:0] acc_t;

  typedef struct packed {
    logic mode;
    acc_t sap;
    acc_t san;
    acc_t saa;
    acc_t spp;
    acc_t snn;
  } tml_row_t;

  localparam logic signed [AccBits:0] SumMax = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [AccBits:0] SumMin = -SumMax;

  function automatic acc_t sat_add(acc_t acc, logic signed [ProdBits-1:0] t);
    logic signed [AccBits:0] s;
    s = (AccBits+1)'(acc) + (AccBits+1)'(t);
    if (s > SumMax) begin
      s = SumMax;
    end else if (s < SumMin) begin
      s = SumMin;
    end
    return s[AccBits-1:0];
  endfunction

endpackage

/* hdl/tml_front.sv */
// Front end: accepts components, forms products and accumulates row sums.
`timescale 1ns / 1ps
module tml_front import tml_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [ElemBits-1:0] in_anchor_value,
  input  logic signed [ElemBits-1:0] in_positive_value,
  input  logic signed [ElemBits-1:0] in_negative_value,
  input  logic                       in_last_in_row,
  input  logic                       mode,
  input  logic signed [15:0]         diff_offset,
  output logic                       q_push,
  output tml_row_t                   q_data,
  input  logic                       q_full
);

  logic signed [DiffBits-1:0] ae, pe, ne, dp, dn;
  logic signed [ProdBits-1:0] m0, m1, m2, m3, m4;
  logic signed [ProdBits-1:0] t0_r, t1_r, t2_r, t3_r, t4_r;
  logic s1_v_r, s1_last_r, s1_mode_r, s1_adv, take;
  acc_t sap_r, san_r, saa_r, spp_r, snn_r;
  acc_t sap_s, san_s, saa_s, spp_s, snn_s;

  assign ae = DiffBits'(in_anchor_value);
  assign pe = DiffBits'(in_positive_value);
  assign ne = DiffBits'(in_negative_value);
  assign dp = ae - pe + DiffBits'(diff_offset);
  assign dn = ae - ne + DiffBits'(diff_offset);

  always_comb begin
    if (mode == MODE_COSINE) begin
      m0 = ProdBits'(ae) * ProdBits'(pe);
      m1 = ProdBits'(ae) * ProdBits'(ne);
      m2 = ProdBits'(ae) * ProdBits'(ae);
      m3 = ProdBits'(pe) * ProdBits'(pe);
      m4 = ProdBits'(ne) * ProdBits'(ne);
    end else begin
      m0 = ProdBits'(dp) * ProdBits'(dp);
      m1 = ProdBits'(dn) * ProdBits'(dn);
      m2 = '0;
      m3 = '0;
      m4 = '0;
    end
  end

  assign s1_adv   = !s1_last_r || !q_full;
  assign in_ready = !s1_v_r || s1_adv;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (take) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      t0_r      <= m0;
      t1_r      <= m1;
      t2_r      <= m2;
      t3_r      <= m3;
      t4_r      <= m4;
      s1_last_r <= in_last_in_row;
      s1_mode_r <= mode;
    end
  end

  assign sap_s = sat_add(sap_r, t0_r);
  assign san_s = sat_add(san_r, t1_r);
  assign saa_s = sat_add(saa_r, t2_r);
  assign spp_s = sat_add(spp_r, t3_r);
  assign snn_s = sat_add(snn_r, t4_r);

  assign q_push = s1_v_r && s1_last_r && !q_full;
  assign q_data = '{mode: s1_mode_r, sap: sap_s, san: san_s, saa: saa_s,
                    spp: spp_s, snn: snn_s};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sap_r <= '0;
      san_r <= '0;
      saa_r <= '0;
      spp_r <= '0;
      snn_r <= '0;
    end else if (s1_v_r && s1_adv) begin
      if (s1_last_r) begin
        sap_r <= '0;
        san_r <= '0;
        saa_r <= '0;
        spp_r <= '0;
        snn_r <= '0;
      end else begin
        sap_r <= sap_s;
        san_r <= san_s;
        saa_r <= saa_s;
        spp_r <= spp_s;
        snn_r <= snn_s;
      end
    end
  end

endmodule

/* hdl/tml_queue.sv */
// Two-entry queue of finished row sums between front and back.
`timescale 1ns / 1ps
module tml_queue import tml_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tml_row_t push_data,
  output logic     full,
  input  logic     pop,
  output tml_row_t pop_data,
  output logic     empty
);

  tml_row_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue pop while empty");
  a_count: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule

/* hdl/tml_back.sv */
// Back end: square roots, cosine division, hinge loss and result register.
`timescale 1ns / 1ps
module tml_back import tml_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  tml_row_t              q_data,
  output logic                  q_pop,
  input  logic [MarginBits-1:0] margin,
  input  logic [15:0]           norm_offset,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OutBits-1:0]    out_loss,
  output logic [OutBits-1:0]    out_distance_positive,
  output logic [OutBits-1:0]    out_distance_negative,
  output logic                  out_hinge_active
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_SQRT = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DSET = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_DFIN = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic [RadBits-1:0] BitTop = RadBits'(1) << (RadBits - 2);
  localparam logic [QuotBits-1:0] QOne  = QuotBits'(65536);
  localparam logic [OutBits:0]    OutMax = {1'b0, {OutBits{1'b1}}};

  logic [3:0] state_r, state_nxt;
  tml_row_t row_r;
  logic [1:0] sq_sel_r;
  logic div_sel_r;
  logic [RadBits-1:0] rad_r, root_r, bit_r, trial, rad_step, root_step, sq_in;
  logic [RootBits-1:0] n0_r, n1_r, n2_r;
  logic [2*RootBits-1:0] prod_r;
  logic [2*RootBits-1:0] rem_r;
  logic [2*RootBits:0] rem2;
  logic [QuotBits-1:0] q_r;
  logic [3:0] cnt_r;
  logic [DistBits-1:0] dp_r, dn_r, cos_dist;
  acc_t sq_src, dot;
  logic [AccBits-1:0] dot_mag;
  logic sq_last;
  logic [OutBits-1:0] dap, dan;
  logic signed [OutBits+1:0] lsum;
  logic [OutBits-1:0] loss;

  // Operand of the current square root.
  always_comb begin
    sq_src = row_r.sap;
    if (row_r.mode == MODE_COSINE) begin
      case (sq_sel_r)
        2'd0:    sq_src = row_r.saa;
        2'd1:    sq_src = row_r.spp;
        default: sq_src = row_r.snn;
      endcase
      sq_in = (sq_src > 0) ? RadBits'(sq_src) : '0;
      sq_in = sq_in + RadBits'(norm_offset);
    end else begin
      sq_src = (sq_sel_r == 2'd0) ? row_r.sap : row_r.san;
      sq_in  = (sq_src > 0) ? (RadBits'(sq_src[AccBits-2:0]) << 8) : '0;
    end
  end

  assign trial     = root_r + bit_r;
  assign rad_step  = (rad_r >= trial) ? rad_r - trial : rad_r;
  assign root_step = (rad_r >= trial) ? (root_r >> 1) + bit_r : (root_r >> 1);
  assign sq_last   = (row_r.mode == MODE_COSINE) ? (sq_sel_r == 2'd2) : (sq_sel_r == 2'd1);

  assign dot      = div_sel_r ? row_r.san : row_r.sap;
  assign dot_mag  = dot[AccBits-1] ? AccBits'(-dot) : AccBits'(dot);
  assign rem2     = {rem_r, 1'b0};
  assign cos_dist = dot[AccBits-1] ? DistBits'(QOne) + DistBits'(q_r)
                                   : DistBits'(QOne) - DistBits'(q_r);

  assign dap  = (row_r.mode == MODE_COSINE) ? OutBits'(dp_r) : OutBits'(n0_r);
  assign dan  = (row_r.mode == MODE_COSINE) ? OutBits'(dn_r) : OutBits'(n1_r);
  assign lsum = (OutBits+2)'(dap) - (OutBits+2)'(dan) + (OutBits+2)'(margin);

  always_comb begin
    if (lsum[OutBits+1]) begin
      loss = '0;
    end else if (lsum[OutBits:0] > OutMax) begin
      loss = OutMax[OutBits-1:0];
    end else begin
      loss = lsum[OutBits-1:0];
    end
  end

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_SQRT;
      S_SQRT: begin
        if (bit_r[1:0] != 2'b00) begin
          if (!sq_last) begin
            state_nxt = S_LOAD;
          end else if (row_r.mode == MODE_COSINE) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL:  state_nxt = S_DSET;
      S_DSET: begin
        if (prod_r == '0 || (2*RootBits)'(dot_mag) >= prod_r) state_nxt = S_DFIN;
        else state_nxt = S_DIV;
      end
      S_DIV:  if (cnt_r == 4'd15) state_nxt = S_DFIN;
      S_DFIN: state_nxt = div_sel_r ? S_DONE : S_MUL;
      S_DONE: state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        row_r     <= q_data;
        sq_sel_r  <= 2'd0;
        div_sel_r <= 1'b0;
      end
      S_LOAD: begin
        rad_r  <= sq_in;
        root_r <= '0;
        bit_r  <= BitTop;
      end
      S_SQRT: begin
        rad_r  <= rad_step;
        root_r <= root_step;
        bit_r  <= bit_r >> 2;
        if (bit_r[1:0] != 2'b00) begin
          case (sq_sel_r)
            2'd0:    n0_r <= root_step[RootBits-1:0];
            2'd1:    n1_r <= root_step[RootBits-1:0];
            default: n2_r <= root_step[RootBits-1:0];
          endcase
          sq_sel_r <= sq_sel_r + 2'd1;
        end
      end
      S_MUL: prod_r <= (2*RootBits)'(n0_r) * (2*RootBits)'(div_sel_r ? n2_r : n1_r);
      S_DSET: begin
        q_r   <= (prod_r != '0 && (2*RootBits)'(dot_mag) >= prod_r) ? QOne : '0;
        rem_r <= (2*RootBits)'(dot_mag);
        cnt_r <= 4'd0;
      end
      S_DIV: begin
        if (rem2 >= (2*RootBits+1)'(prod_r)) begin
          rem_r <= rem2[2*RootBits-1:0] - prod_r;
          q_r   <= {q_r[QuotBits-2:0], 1'b1};
        end else begin
          rem_r <= rem2[2*RootBits-1:0];
          q_r   <= {q_r[QuotBits-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 4'd1;
      end
      S_DFIN: begin
        if (div_sel_r) dn_r <= cos_dist;
        else           dp_r <= cos_dist;
        div_sel_r <= 1'b1;
      end
      S_DONE: begin
        out_loss              <= loss;
        out_distance_positive <= dap;
        out_distance_negative <= dan;
        out_hinge_active      <= loss != '0;
      end
      default: ;
    endcase
  end

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> state_r == S_OUT)
    else $error("result shown outside output state");
  a_hinge: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_hinge_active == (out_loss != '0))
    else $error("hinge flag disagrees with loss");
  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == S_SQRT |-> $onehot(bit_r))
    else $error("square root bit lost");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
      q_pop |=> state_r == S_LOAD)
    else $error("row popped without starting");

endmodule

/* hdl/triplet_margin_loss_unit.sv */
// The back end runs two square roots in Euclidean mode and three in cosine mode, each of 28
// steps, and in cosine mode two divisions of up to 16 steps. Throughput: one component per
// cycle while the queue can take a finished row; a row-end result waits in a two-entry queue
// while the next row accumulates, so rows longer than the back-end time run at full rate.
// Synchronous active-low reset clears sums, queue and state.
`timescale 1ns / 1ps
module triplet_margin_loss_unit import tml_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [ElemBits-1:0] in_anchor_value,
  input  logic signed [ElemBits-1:0] in_positive_value,
  input  logic signed [ElemBits-1:0] in_negative_value,
  input  logic                       in_last_in_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [OutBits-1:0]         out_loss,
  output logic [OutBits-1:0]         out_distance_positive,
  output logic [OutBits-1:0]         out_distance_negative,
  output logic                       out_hinge_active,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CfgIdxBits-1:0]      cfg_index,
  input  logic [CfgDataBits-1:0]     cfg_data
);

  logic                  mode_r;
  logic [MarginBits-1:0] margin_r;
  logic signed [15:0]    diff_offset_r;
  logic [15:0]           norm_offset_r;
  logic                  q_push, q_full, q_pop, q_empty;
  tml_row_t              q_in, q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_EUCLID;
      margin_r      <= MarginBits'(65536);
      diff_offset_r <= '0;
      norm_offset_r <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DISTANCE_MODE:     mode_r        <= cfg_data[0];
        CFG_MARGIN:            margin_r      <= cfg_data[MarginBits-1:0];
        CFG_DIFFERENCE_OFFSET: diff_offset_r <= cfg_data[15:0];
        CFG_NORM_OFFSET:       norm_offset_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  tml_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_anchor_value, .in_positive_value, .in_negative_value, .in_last_in_row,
    .mode(mode_r), .diff_offset(diff_offset_r),
    .q_push, .q_data(q_in), .q_full
  );

  tml_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  tml_back u_back (
    .clk, .rst_n, .q_empty, .q_data(q_out), .q_pop,
    .margin(margin_r), .norm_offset(norm_offset_r),
    .out_valid, .out_ready, .out_loss, .out_distance_positive,
    .out_distance_negative, .out_hinge_active
  );

endmodule
